[src/lmcd_pkg.sv]
// Package for the LRU/MRU block cache directory.
// Holds the sizing constants, the sequencer state type and the structs shared
// between the tag match, the controller and the top level. No dependencies.
package lmcd_pkg;

    localparam int SLOT_COUNT    = 64;
    localparam int ADDRESS_BITS  = 40;
    localparam int SLOT_BITS     = $clog2(SLOT_COUNT);
    localparam int FILL_BITS     = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_OUT_BITS = 6;
    localparam int MISS_BITS     = 16;
    localparam int TAG_WORD_BITS = ADDRESS_BITS + 1;

    localparam logic [MISS_BITS-1:0] MISS_MAX  = '1;
    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(SLOT_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_LINK,
        ST_UPDATE,
        ST_EMIT
    } lmcd_state_t;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
    } lmcd_match_t;

    typedef struct packed {
        logic                    en;
        logic [SLOT_BITS-1:0]    idx;
        logic [ADDRESS_BITS-1:0] tag;
    } lmcd_cam_wr_t;

    typedef struct packed {
        logic                     hit;
        logic [SLOT_OUT_BITS-1:0] slot;
        logic                     fetch_needed;
        logic                     writeback_needed;
        logic [ADDRESS_BITS-1:0]  evicted_block;
        logic                     replaced;
        logic [MISS_BITS-1:0]     request_misses;
        logic                     last;
    } lmcd_result_t;

endpackage

[src/lmcd_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while the read enable is low. No dependencies.
module lmcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/lmcd_tag_match.sv]
// Parallel tag match of the directory: one tag register and comparator per slot.
// The match vector is registered at lookup, then priority encoded to the lowest slot.
// Depends on lmcd_pkg.
module lmcd_tag_match
    import lmcd_pkg::*;
(
    input  logic                    clk,
    input  logic                    capture,
    input  logic [ADDRESS_BITS-1:0] lookup_addr,
    input  logic [FILL_BITS-1:0]    fill_count,
    input  lmcd_cam_wr_t            cam_wr,
    output lmcd_match_t             match
);

    logic [ADDRESS_BITS-1:0] tag_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   match_vec_reg;

    always_ff @(posedge clk)
    begin
        if (cam_wr.en)
        begin
            tag_reg[cam_wr.idx] <= cam_wr.tag;
        end
        // Only filled slots take part; unfilled tag registers hold garbage.
        if (capture)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                match_vec_reg[i] <= (FILL_BITS'(i) < fill_count) &&
                                    (tag_reg[i] == lookup_addr);
            end
        end
    end

    always_comb
    begin
        match.hit  = |match_vec_reg;
        match.slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (match_vec_reg[i])
            begin
                match.slot = SLOT_BITS'(i);
            end
        end
    end

endmodule

[src/lmcd_ctrl.sv]
// Access sequencer: resolves hit, free slot or victim, then updates the recency list and
// the tag/dirty memory with read-modify-write steps. Depends on lmcd_pkg and lmcd_ram.
module lmcd_ctrl
    import lmcd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ADDRESS_BITS-1:0] block_address,
    input  logic                    is_write,
    input  logic                    last_of_request,
    input  logic                    policy,
    input  lmcd_match_t             match,
    output logic [FILL_BITS-1:0]    fill_count,
    output lmcd_cam_wr_t            cam_wr,
    input  logic                    out_free,
    output logic                    emit,
    output lmcd_result_t            result
);

    lmcd_state_t state_reg, state_next;

    logic [ADDRESS_BITS-1:0] addr_reg;
    logic                    wr_reg;
    logic                    last_reg;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic                    hit_reg;
    logic                    app_reg;
    logic                    repl_reg;
    logic                    wb_reg;
    logic [ADDRESS_BITS-1:0] evict_reg;

    logic [SLOT_BITS-1:0]    newest_reg, newest_next;
    logic [SLOT_BITS-1:0]    oldest_reg, oldest_next;
    logic [FILL_BITS-1:0]    filled_reg, filled_next;
    logic [MISS_BITS-1:0]    miss_reg, miss_next;

    logic                    accept;
    logic [SLOT_BITS-1:0]    res_slot;
    logic                    res_app;
    logic                    res_repl;
    logic                    rd_en;
    logic                    move;
    logic                    link_append;

    logic                     tag_we;
    logic [TAG_WORD_BITS-1:0] tag_wdata;
    logic [TAG_WORD_BITS-1:0] tag_q;
    logic                     newer_we;
    logic [SLOT_BITS-1:0]     newer_waddr;
    logic [SLOT_BITS-1:0]     newer_wdata;
    logic [SLOT_BITS-1:0]     newer_q;
    logic                     older_we;
    logic [SLOT_BITS-1:0]     older_waddr;
    logic [SLOT_BITS-1:0]     older_wdata;
    logic [SLOT_BITS-1:0]     older_q;

    assign accept     = in_valid && in_ready;
    assign fill_count = filled_reg;

    // A hit or a replacement moves the slot to the newest end unless it is there already.
    assign move        = (hit_reg || repl_reg) && (slot_reg != newest_reg);
    assign link_append = app_reg && (filled_reg != '0);

    // Slot selection: hit slot, else the next never-used slot, else the policy victim.
    always_comb
    begin
        res_app  = 1'b0;
        res_repl = 1'b0;
        if (match.hit)
        begin
            res_slot = match.slot;
        end
        else if (filled_reg != FILL_FULL)
        begin
            res_slot = filled_reg[SLOT_BITS-1:0];
            res_app  = 1'b1;
        end
        else
        begin
            res_slot = policy ? newest_reg : oldest_reg;
            res_repl = 1'b1;
        end
    end

    lmcd_ram #(
        .WIDTH (TAG_WORD_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (slot_reg),
        .wdata (tag_wdata),
        .re    (rd_en),
        .raddr (res_slot),
        .rdata (tag_q)
    );

    lmcd_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_newer_ram (
        .clk   (clk),
        .we    (newer_we),
        .waddr (newer_waddr),
        .wdata (newer_wdata),
        .re    (rd_en),
        .raddr (res_slot),
        .rdata (newer_q)
    );

    lmcd_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_older_ram (
        .clk   (clk),
        .we    (older_we),
        .waddr (older_waddr),
        .wdata (older_wdata),
        .re    (rd_en),
        .raddr (res_slot),
        .rdata (older_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: state_next = ST_LINK;
            ST_LINK:    state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_RESOLVE : ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // State outputs and memory writes.
    always_comb
    begin
        in_ready    = 1'b0;
        emit        = 1'b0;
        rd_en       = 1'b0;
        tag_we      = 1'b0;
        newer_we    = 1'b0;
        newer_waddr = older_q;
        newer_wdata = newer_q;
        older_we    = 1'b0;
        older_waddr = newer_q;
        older_wdata = older_q;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_RESOLVE:
            begin
                rd_en = 1'b1;
            end
            ST_LINK:
            begin
                // Unlink the slot from its neighbors.
                if (move)
                begin
                    newer_we = (slot_reg != oldest_reg);
                    older_we = 1'b1;
                end
            end
            ST_UPDATE:
            begin
                tag_we = 1'b1;
                // Link the slot in behind the current newest slot.
                if (move || link_append)
                begin
                    older_we    = 1'b1;
                    older_waddr = slot_reg;
                    older_wdata = newest_reg;
                    newer_we    = 1'b1;
                    newer_waddr = newest_reg;
                    newer_wdata = slot_reg;
                end
            end
            ST_EMIT:
            begin
                in_ready = out_free;
                emit     = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        filled_next = filled_reg;
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        miss_next   = miss_reg;
        unique case (state_reg)
            ST_LINK:
            begin
                if (move && (slot_reg == oldest_reg))
                begin
                    oldest_next = newer_q;
                end
            end
            ST_UPDATE:
            begin
                if (move || link_append)
                begin
                    newest_next = slot_reg;
                end
                if (app_reg)
                begin
                    filled_next = filled_reg + 1'b1;
                    if (filled_reg == '0)
                    begin
                        newest_next = slot_reg;
                        oldest_next = slot_reg;
                    end
                end
                if (!hit_reg && (miss_reg != MISS_MAX))
                begin
                    miss_next = miss_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free && last_reg)
                begin
                    miss_next = '0;
                end
            end
            default:
            begin
                miss_next = miss_reg;
            end
        endcase
    end

    // On a hit the stored dirty bit is kept and a write sets it; a fill takes the write flag.
    assign tag_wdata = {(hit_reg ? (tag_q[ADDRESS_BITS] | wr_reg) : wr_reg), addr_reg};

    assign cam_wr.en  = (state_reg == ST_UPDATE) && !hit_reg;
    assign cam_wr.idx = slot_reg;
    assign cam_wr.tag = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            newest_reg <= '0;
            oldest_reg <= '0;
            filled_reg <= '0;
            miss_reg   <= '0;
            hit_reg    <= 1'b0;
            app_reg    <= 1'b0;
            repl_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
            filled_reg <= filled_next;
            miss_reg   <= miss_next;
            if (state_reg == ST_RESOLVE)
            begin
                hit_reg  <= match.hit;
                app_reg  <= res_app;
                repl_reg <= res_repl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= block_address;
            wr_reg   <= is_write;
            last_reg <= last_of_request;
        end
        if (state_reg == ST_RESOLVE)
        begin
            slot_reg <= res_slot;
        end
        if (state_reg == ST_UPDATE)
        begin
            wb_reg    <= repl_reg && tag_q[ADDRESS_BITS];
            evict_reg <= repl_reg ? tag_q[ADDRESS_BITS-1:0] : '0;
        end
    end

    assign result.hit              = hit_reg;
    assign result.slot             = SLOT_OUT_BITS'(slot_reg);
    assign result.fetch_needed     = !hit_reg;
    assign result.writeback_needed = wb_reg;
    assign result.evicted_block    = evict_reg;
    assign result.replaced         = repl_reg;
    assign result.request_misses   = miss_reg;
    assign result.last             = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_FULL)
        else $error("fill count exceeds the slot count");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) && !hit_reg && (filled_reg != FILL_FULL)
        |=> filled_reg == $past(filled_reg) + 1'b1)
        else $error("miss into a free slot did not advance the fill count");

    a_repl_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) && repl_reg |-> filled_reg == FILL_FULL)
        else $error("replacement while never-used slots remain");

    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && (filled_reg >= FILL_BITS'(2))
        |-> newest_reg != oldest_reg)
        else $error("recency list ends coincide with two or more slots filled");

    a_miss_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_free && last_reg |=> miss_reg == '0)
        else $error("request miss count not cleared after the last block");

endmodule

[src/lru_mru_block_cache_directory.sv]
// Fully associative block cache directory with LRU or MRU victim selection.
// An access passes the resolve, link, update and emit states; emit holds while the
// output is full. A new access waits until the last is emitted: the recency-link
// memories need one read, then unlink and relink writes on their single write ports.
// Reset: directory empty, request miss count zero, victim policy LRU; no clearing pass.
module lru_mru_block_cache_directory
    import lmcd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ADDRESS_BITS-1:0]  block_address,
    input  logic                     is_write,
    input  logic                     last_of_request,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [SLOT_OUT_BITS-1:0] slot,
    output logic                     fetch_needed,
    output logic                     writeback_needed,
    output logic [ADDRESS_BITS-1:0]  evicted_block,
    output logic                     replaced,
    output logic [MISS_BITS-1:0]     request_misses,
    output logic                     last
);

    logic           policy_reg;
    logic           out_valid_reg;
    lmcd_result_t   out_reg;
    logic           out_free;
    logic           emit;
    logic           capture;
    lmcd_result_t   result;
    lmcd_match_t    match;
    lmcd_cam_wr_t   cam_wr;
    logic [FILL_BITS-1:0] fill_count;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign capture   = in_valid && in_ready;

    lmcd_tag_match u_tag_match (
        .clk         (clk),
        .capture     (capture),
        .lookup_addr (block_address),
        .fill_count  (fill_count),
        .cam_wr      (cam_wr),
        .match       (match)
    );

    lmcd_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .block_address   (block_address),
        .is_write        (is_write),
        .last_of_request (last_of_request),
        .policy          (policy_reg),
        .match           (match),
        .fill_count      (fill_count),
        .cam_wr          (cam_wr),
        .out_free        (out_free),
        .emit            (emit),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result register frees the controller to take the next transaction.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hit              = out_reg.hit;
    assign slot             = out_reg.slot;
    assign fetch_needed     = out_reg.fetch_needed;
    assign writeback_needed = out_reg.writeback_needed;
    assign evicted_block    = out_reg.evicted_block;
    assign replaced         = out_reg.replaced;
    assign request_misses   = out_reg.request_misses;
    assign last             = out_reg.last;

endmodule
